>>> hw/rtl/mbpdu_pkg.sv
// Shared types, codes and constants for the Modbus request PDU builder.
package mbpdu_pkg;

    localparam int MAX_COILS   = 1000;
    localparam int MAX_REGS    = 120;
    localparam int PTS_W       = 10;
    localparam int JOB_BYTES   = 7;
    localparam int IDX_W       = $clog2(JOB_BYTES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PTS_W-1:0] MAX_COILS_P = PTS_W'(MAX_COILS);
    localparam logic [PTS_W-1:0] MAX_REGS_P  = PTS_W'(MAX_REGS);

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_DATA  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        TYPE_OUT_COIL = 2'd0,
        TYPE_IN_COIL  = 2'd1,
        TYPE_IN_REG   = 2'd2,
        TYPE_HOLD_REG = 2'd3
    } point_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_TYPE   = 2'd1,
        STATUS_RANGE      = 2'd2,
        STATUS_UNEXPECTED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_SCOIL = 3'd1,
        MODE_MCOIL = 3'd2,
        MODE_SREG  = 3'd3,
        MODE_MREG  = 3'd4
    } mode_t;

    localparam logic [7:0] FC_READ_COILS   = 8'h01;
    localparam logic [7:0] FC_READ_INPUTS  = 8'h02;
    localparam logic [7:0] FC_READ_HOLD    = 8'h03;
    localparam logic [7:0] FC_READ_INREG   = 8'h04;
    localparam logic [7:0] FC_WRITE_COIL   = 8'h05;
    localparam logic [7:0] FC_WRITE_REG    = 8'h06;
    localparam logic [7:0] FC_WRITE_COILS  = 8'h0F;
    localparam logic [7:0] FC_WRITE_REGS   = 8'h10;
    localparam logic [7:0] COIL_ON         = 8'hFF;
    localparam logic [7:0] COIL_OFF        = 8'h00;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  slave_id;
        logic [1:0]  point_kind;
        logic [15:0] base_addr;
        logic [15:0] offset;
        logic [15:0] total_points;
        logic [15:0] write_points;
        logic        single_only;
        logic [15:0] data_value;
    } req_t;

    typedef struct packed {
        logic [7:0]       pdu_byte;
        logic             last_byte;
        logic [1:0]       status;
        logic [PTS_W-1:0] points_used;
    } pdu_t;

    // One classified item: the bytes it sends and how to mark them.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [IDX_W-1:0]          last_idx;
        logic                      final_last;
        logic [1:0]                status;
        logic [PTS_W-1:0]          points;
    } job_t;

endpackage

>>> hw/rtl/mbpdu_front.sv
// Front end: accepts request items, tracks the pending write and builds byte jobs.
module mbpdu_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  mbpdu_pkg::req_t   req,
    input  logic              job_ready,
    output logic              job_push,
    output mbpdu_pkg::job_t   job
);

    mbpdu_pkg::mode_t              mode_reg, mode_next;
    logic [mbpdu_pkg::PTS_W-1:0]   points_left_reg, points_left_next;
    logic [7:0]                    bit_buffer_reg, bit_buffer_next;
    logic [2:0]                    bit_count_reg, bit_count_next;

    logic                          accept;
    logic [15:0]                   wire_addr;
    logic [15:0]                   read_diff;
    logic [16:0]                   write_end;
    logic [mbpdu_pkg::PTS_W-1:0]   max_pts;
    logic [mbpdu_pkg::PTS_W-1:0]   pts;
    logic [mbpdu_pkg::PTS_W-1:0]   pl_dec;
    logic [mbpdu_pkg::PTS_W:0]     coil_round;
    logic [mbpdu_pkg::PTS_W:0]     reg_bytes;
    logic [7:0]                    byte_count;
    logic [7:0]                    buf_new;
    logic                          coil_on;
    logic [7:0]                    read_fc;
    logic                          is_coil_w;

    assign req_stall = !job_ready;
    assign accept    = req_valid && job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= mbpdu_pkg::MODE_IDLE;
            points_left_reg <= '0;
            bit_buffer_reg  <= '0;
            bit_count_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg        <= mode_next;
            points_left_reg <= points_left_next;
            bit_buffer_reg  <= bit_buffer_next;
            bit_count_reg   <= bit_count_next;
        end
    end

    always_comb
    begin
        wire_addr  = req.base_addr + req.offset + 16'hFFFF;
        read_diff  = req.total_points - req.offset;
        write_end  = {1'b0, req.offset} + {1'b0, req.write_points};
        coil_on    = (req.data_value != 16'd0);
        is_coil_w  = (req.point_kind == mbpdu_pkg::TYPE_OUT_COIL);
        pl_dec     = points_left_reg - mbpdu_pkg::PTS_W'(1);
        buf_new    = bit_buffer_reg | (8'(coil_on) << bit_count_reg);

        case (req.point_kind)
            mbpdu_pkg::TYPE_OUT_COIL: read_fc = mbpdu_pkg::FC_READ_COILS;
            mbpdu_pkg::TYPE_IN_COIL:  read_fc = mbpdu_pkg::FC_READ_INPUTS;
            mbpdu_pkg::TYPE_IN_REG:   read_fc = mbpdu_pkg::FC_READ_INREG;
            default:                  read_fc = mbpdu_pkg::FC_READ_HOLD;
        endcase
        max_pts = req.point_kind[1] ? mbpdu_pkg::MAX_REGS_P : mbpdu_pkg::MAX_COILS_P;

        pts = '0;
        if (req.action == mbpdu_pkg::ACT_READ)
        begin
            pts = (read_diff > 16'(max_pts)) ? max_pts : read_diff[mbpdu_pkg::PTS_W-1:0];
        end
        else if (req.action == mbpdu_pkg::ACT_WRITE)
        begin
            pts = (req.write_points > 16'(max_pts)) ? max_pts
                                                    : req.write_points[mbpdu_pkg::PTS_W-1:0];
            if (req.single_only)
                pts = mbpdu_pkg::PTS_W'(1);
        end

        coil_round = ({1'b0, pts} + (mbpdu_pkg::PTS_W + 1)'(7)) >> 3;
        reg_bytes  = {pts, 1'b0};
        byte_count = is_coil_w ? coil_round[7:0] : reg_bytes[7:0];

        mode_next        = mode_reg;
        points_left_next = points_left_reg;
        bit_buffer_next  = bit_buffer_reg;
        bit_count_next   = bit_count_reg;
        job_push         = 1'b0;
        job              = '0;

        case (req.action)
            mbpdu_pkg::ACT_READ:
            begin
                mode_next        = mbpdu_pkg::MODE_IDLE;
                points_left_next = '0;
                bit_buffer_next  = '0;
                bit_count_next   = '0;
                job_push         = accept;
                if (req.offset > req.total_points)
                begin
                    job.final_last = 1'b1;
                    job.status     = mbpdu_pkg::STATUS_RANGE;
                end
                else
                begin
                    job.bytes[0]   = req.slave_id;
                    job.bytes[1]   = read_fc;
                    job.bytes[2]   = wire_addr[15:8];
                    job.bytes[3]   = wire_addr[7:0];
                    job.bytes[4]   = 8'(pts >> 8);
                    job.bytes[5]   = pts[7:0];
                    job.last_idx   = mbpdu_pkg::IDX_W'(5);
                    job.final_last = 1'b1;
                    job.points     = pts;
                end
            end
            mbpdu_pkg::ACT_WRITE:
            begin
                mode_next        = mbpdu_pkg::MODE_IDLE;
                points_left_next = '0;
                bit_buffer_next  = '0;
                bit_count_next   = '0;
                job_push         = accept;
                if (write_end > {1'b0, req.total_points} || req.write_points == 16'd0)
                begin
                    job.final_last = 1'b1;
                    job.status     = mbpdu_pkg::STATUS_RANGE;
                end
                else if (req.point_kind != mbpdu_pkg::TYPE_OUT_COIL &&
                         req.point_kind != mbpdu_pkg::TYPE_HOLD_REG)
                begin
                    job.final_last = 1'b1;
                    job.status     = mbpdu_pkg::STATUS_BAD_TYPE;
                end
                else
                begin
                    points_left_next = pts;
                    job.bytes[0]     = req.slave_id;
                    job.bytes[2]     = wire_addr[15:8];
                    job.bytes[3]     = wire_addr[7:0];
                    job.points       = pts;
                    if (req.single_only)
                    begin
                        mode_next    = is_coil_w ? mbpdu_pkg::MODE_SCOIL : mbpdu_pkg::MODE_SREG;
                        job.bytes[1] = is_coil_w ? mbpdu_pkg::FC_WRITE_COIL
                                                 : mbpdu_pkg::FC_WRITE_REG;
                        job.last_idx = mbpdu_pkg::IDX_W'(3);
                    end
                    else
                    begin
                        mode_next    = is_coil_w ? mbpdu_pkg::MODE_MCOIL : mbpdu_pkg::MODE_MREG;
                        job.bytes[1] = is_coil_w ? mbpdu_pkg::FC_WRITE_COILS
                                                 : mbpdu_pkg::FC_WRITE_REGS;
                        job.bytes[4] = 8'(pts >> 8);
                        job.bytes[5] = pts[7:0];
                        job.bytes[6] = byte_count;
                        job.last_idx = mbpdu_pkg::IDX_W'(6);
                    end
                end
            end
            mbpdu_pkg::ACT_DATA:
            begin
                case (mode_reg)
                    mbpdu_pkg::MODE_SCOIL:
                    begin
                        job_push         = accept;
                        job.bytes[0]     = coil_on ? mbpdu_pkg::COIL_ON : mbpdu_pkg::COIL_OFF;
                        job.bytes[1]     = mbpdu_pkg::COIL_OFF;
                        job.last_idx     = mbpdu_pkg::IDX_W'(1);
                        job.final_last   = 1'b1;
                        mode_next        = mbpdu_pkg::MODE_IDLE;
                        points_left_next = '0;
                    end
                    mbpdu_pkg::MODE_SREG:
                    begin
                        job_push         = accept;
                        job.bytes[0]     = req.data_value[15:8];
                        job.bytes[1]     = req.data_value[7:0];
                        job.last_idx     = mbpdu_pkg::IDX_W'(1);
                        job.final_last   = 1'b1;
                        mode_next        = mbpdu_pkg::MODE_IDLE;
                        points_left_next = '0;
                    end
                    mbpdu_pkg::MODE_MREG:
                    begin
                        job_push         = accept;
                        job.bytes[0]     = req.data_value[15:8];
                        job.bytes[1]     = req.data_value[7:0];
                        job.last_idx     = mbpdu_pkg::IDX_W'(1);
                        job.final_last   = (pl_dec == '0);
                        points_left_next = pl_dec;
                        if (pl_dec == '0)
                            mode_next = mbpdu_pkg::MODE_IDLE;
                    end
                    mbpdu_pkg::MODE_MCOIL:
                    begin
                        points_left_next = pl_dec;
                        // a byte goes out when it fills or when the last coil arrives
                        if (bit_count_reg == 3'd7 || pl_dec == '0)
                        begin
                            job_push        = accept;
                            job.bytes[0]    = buf_new;
                            job.final_last  = (pl_dec == '0);
                            bit_buffer_next = '0;
                            bit_count_next  = '0;
                            if (pl_dec == '0)
                                mode_next = mbpdu_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            bit_buffer_next = buf_new;
                            bit_count_next  = bit_count_reg + 3'd1;
                        end
                    end
                    default:
                    begin
                        job_push       = accept;
                        job.final_last = 1'b1;
                        job.status     = mbpdu_pkg::STATUS_UNEXPECTED;
                    end
                endcase
            end
            default:
            begin
                job_push = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == mbpdu_pkg::MODE_IDLE |->
            points_left_reg == '0 && bit_count_reg == '0 && bit_buffer_reg == '0)
        else $error("idle mode with leftover write state");

    a_multi_left: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == mbpdu_pkg::MODE_MCOIL || mode_reg == mbpdu_pkg::MODE_MREG) |->
            points_left_reg != '0)
        else $error("multiple write pending with no points left");

    a_single_left: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == mbpdu_pkg::MODE_SCOIL || mode_reg == mbpdu_pkg::MODE_SREG) |->
            points_left_reg == mbpdu_pkg::PTS_W'(1) && bit_count_reg == '0)
        else $error("single write pending with wrong point count");
`endif

endmodule

>>> hw/rtl/mbpdu_queue.sv
// Short job queue between the front end and the byte serializer.
module mbpdu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbpdu_pkg::job_t push_job,
    output logic            ready,
    input  logic            pop,
    output logic            valid,
    output mbpdu_pkg::job_t pop_job
);

    mbpdu_pkg::job_t                 slot_reg [mbpdu_pkg::QUEUE_DEPTH];
    logic [mbpdu_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mbpdu_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mbpdu_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign ready   = (count_reg != mbpdu_pkg::QCNT_W'(mbpdu_pkg::QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_job = slot_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == mbpdu_pkg::QPTR_W'(mbpdu_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + mbpdu_pkg::QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == mbpdu_pkg::QPTR_W'(mbpdu_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + mbpdu_pkg::QPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + mbpdu_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - mbpdu_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> hw/rtl/mbpdu_back.sv
// Back end: walks each job byte by byte into the registered output.
module mbpdu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  mbpdu_pkg::job_t job,
    output logic            job_pop,
    output logic            pdu_valid,
    input  logic            pdu_stall,
    output mbpdu_pkg::pdu_t pdu
);

    mbpdu_pkg::job_t               cur_reg;
    logic                          busy_reg, busy_next;
    logic [mbpdu_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                          out_valid_reg, out_valid_next;
    mbpdu_pkg::pdu_t               out_reg;
    logic                          can_send;
    logic                          send;
    logic                          finish;

    assign can_send = !out_valid_reg || !pdu_stall;
    assign send     = busy_reg && can_send;
    assign finish   = send && (idx_reg == cur_reg.last_idx);
    assign job_pop  = job_valid && (!busy_reg || finish);

    assign pdu_valid = out_valid_reg;
    assign pdu       = out_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (send)
            out_valid_next = 1'b1;
        else if (!pdu_stall)
            out_valid_next = 1'b0;
        if (job_pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (finish)
            busy_next = 1'b0;
        else if (send)
            idx_next = idx_reg + mbpdu_pkg::IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
            cur_reg <= job;
        if (send)
        begin
            out_reg.pdu_byte    <= cur_reg.bytes[idx_reg];
            out_reg.last_byte   <= finish && cur_reg.final_last;
            out_reg.status      <= cur_reg.status;
            out_reg.points_used <= cur_reg.points;
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg <= cur_reg.last_idx)
        else $error("byte index past end of job");

    a_pop_start: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> busy_reg && idx_reg == '0)
        else $error("popped job did not start at first byte");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status != mbpdu_pkg::STATUS_OK |->
            out_reg.last_byte && out_reg.pdu_byte == 8'd0)
        else $error("error result not a single marked zero byte");
`endif

endmodule

>>> hw/rtl/modbus_request_pdu_builder.sv
// Top level of the Modbus request PDU builder: front end, job queue, byte serializer.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/req_stall mbpdu_pkg::req_t (one request item)
//   pdu      out  pdu_valid/pdu_stall mbpdu_pkg::pdu_t (one PDU byte)
//
// The front end takes one item per cycle while the two-entry job queue has room.
// The serializer sends one byte per cycle while pdu is not stalled: a read header is 6
// bytes, a write header 4 or 7, a data item 0 to 2 (a coil short of a full byte sends
// none), an error 1; the output byte rate sets throughput.
// Reset clears the pending write, the queue and the output valid flag.
// A stall on pdu backs up through the queue to req_stall; the front end needs no wait.
module modbus_request_pdu_builder (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  mbpdu_pkg::req_t req,
    output logic            pdu_valid,
    input  logic            pdu_stall,
    output mbpdu_pkg::pdu_t pdu
);

    logic            q_ready;
    logic            q_push;
    mbpdu_pkg::job_t q_in;
    logic            q_valid;
    logic            q_pop;
    mbpdu_pkg::job_t q_out;

    mbpdu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .job_ready (q_ready),
        .job_push  (q_push),
        .job       (q_in)
    );

    mbpdu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_job  (q_out)
    );

    mbpdu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (q_out),
        .job_pop   (q_pop),
        .pdu_valid (pdu_valid),
        .pdu_stall (pdu_stall),
        .pdu       (pdu)
    );

endmodule
